// File: sv/key_auto_repeat_engine_top_assert.svh
// Assertion macros shared by the key auto-repeat engine modules.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef KEY_AUTO_REPEAT_ENGINE_TOP_ASSERT_SVH
`define KEY_AUTO_REPEAT_ENGINE_TOP_ASSERT_SVH

// cons must hold in the same cycle as ante
`define KARE_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// cons must hold in the cycle after ante
`define KARE_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// cond must never hold
`define KARE_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

// File: sv/kare_pkg.sv
// Shared types and constants of the key auto-repeat engine.
// No dependencies; used by kare_front, kare_back and key_auto_repeat_engine_top.
package kare_pkg;

    localparam int KEY_W       = 8;
    localparam int MOD_W       = 8;
    localparam int DELTA_W     = 12;
    localparam int TIME_W      = 18;
    localparam int CFG_W       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_PRESS   = 2'd0;
    localparam t_cmd CMD_RELEASE = 2'd1;
    localparam t_cmd CMD_TICK    = 2'd2;

    localparam logic EV_PRESSED  = 1'b0;
    localparam logic EV_RELEASED = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD = 2'd2;

    localparam logic [CFG_W-1:0] MIN_PERIOD    = 16'd10;
    localparam logic [CFG_W-1:0] RESET_DELAY   = 16'd500;
    localparam logic [CFG_W-1:0] RESET_PERIOD  = 16'd50;
    localparam logic             RESET_ENABLE  = 1'b1;
    localparam logic [TIME_W-1:0] TIME_MIN     = 18'h20000;

    typedef struct packed {
        t_cmd               cmd;
        logic [KEY_W-1:0]   key;
        logic [MOD_W-1:0]   mods;
        logic               is_rep;
        logic [DELTA_W-1:0] delta;
    } t_item;

    typedef struct packed {
        logic             enable;
        logic [CFG_W-1:0] delay;
        logic [CFG_W-1:0] period;
    } t_cfg;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic [MOD_W-1:0] mods;
        logic             rep;
        logic             full;
    } t_event;

endpackage

// File: sv/kare_front.sv
// Front end: accepts input requests, drops those with no effect, queues the rest.
// Depends on kare_pkg; feeds kare_back through a two-entry queue.
module kare_front #(
    parameter int NUM_KEYS = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] key_code, [15:8] modifier_bits, [16] press_is_repeat,
    // [28:17] tick_delta_ms, [31:29] zero
    input  logic [kare_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]                     s_axis_tuser,
    input  logic                           i_repeat_enable,
    output logic                           o_q_valid,
    output kare_pkg::t_item                o_q_item,
    input  logic                           i_q_pop
);

    kare_pkg::t_item w_item;
    logic            w_key_ok;
    logic            w_keep;
    logic            w_push;

    kare_pkg::t_item r_q [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_cnt;

    always_comb begin
        w_item.cmd    = s_axis_tuser;
        w_item.key    = s_axis_tdata[7:0];
        w_item.mods   = s_axis_tdata[15:8];
        w_item.is_rep = s_axis_tdata[16];
        w_item.delta  = s_axis_tdata[28:17];
        w_key_ok      = {1'b0, w_item.key} < 9'(NUM_KEYS);
        unique case (w_item.cmd)
            kare_pkg::CMD_PRESS:   w_keep = w_key_ok;
            kare_pkg::CMD_RELEASE: w_keep = w_key_ok;
            kare_pkg::CMD_TICK:    w_keep = i_repeat_enable;
            default:               w_keep = 1'b0;
        endcase
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready && w_keep;
    assign o_q_valid     = (r_cnt != 2'd0);
    assign o_q_item      = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

// File: sv/kare_back.sv
// Back end: walks the held-key table for each queued request and emits events.
// Depends on kare_pkg and key_auto_repeat_engine_top_assert.svh.
`include "key_auto_repeat_engine_top_assert.svh"

module kare_back #(
    parameter int HELD_SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kare_pkg::t_cfg                  i_cfg,
    input  logic                            i_q_valid,
    input  kare_pkg::t_item                 i_q_item,
    output logic                            o_q_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] event_key, [15:8] event_modifiers, [16] event_repeat,
    // [17] tracking_full, [23:18] zero
    output logic [kare_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] event_kind
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam int SlotW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FINISH = 4'b0100,
        S_FLUSH  = 4'b1000
    } t_state;

    t_state                             r_state;
    kare_pkg::t_item                    r_cur;
    logic [kare_pkg::MOD_W-1:0]         r_mods;
    logic [HELD_SLOTS-1:0]              r_valid;
    logic [kare_pkg::KEY_W-1:0]         mem_key  [HELD_SLOTS];
    logic signed [kare_pkg::TIME_W-1:0] mem_time [HELD_SLOTS];
    logic [SlotW-1:0]                   r_addr;
    logic                               r_addr_vld;
    logic                               r_ev_vld;
    logic [SlotW-1:0]                   r_ev_idx;
    logic [kare_pkg::KEY_W-1:0]         r_rd_key;
    logic signed [kare_pkg::TIME_W-1:0] r_rd_time;
    logic                               r_match_vld;
    logic [SlotW-1:0]                   r_match_idx;
    logic                               r_free_vld;
    logic [SlotW-1:0]                   r_free_idx;
    logic                               r_hold_vld;
    kare_pkg::t_event                   r_hold;
    logic [kare_pkg::CNT_W-1:0]         r_emit_cnt;
    logic                               r_out_vld;
    kare_pkg::t_event                   r_out;
    logic                               r_out_last;

    logic                               w_out_free;
    logic                               w_slot_vld;
    logic                               w_is_tick;
    logic signed [kare_pkg::TIME_W:0]   w_diff;
    logic signed [kare_pkg::TIME_W-1:0] w_tsat;
    logic                               w_due;
    logic                               w_fire;
    logic                               w_stall;
    logic                               w_advance;
    logic signed [kare_pkg::TIME_W-1:0] n_time;
    logic                               w_tick_wr;
    logic                               w_push_hold;
    logic                               w_flush_push;
    logic                               w_arm_req;
    logic                               w_arm_ok;
    logic [SlotW-1:0]                   w_arm_idx;
    logic                               w_finish_arm;
    logic                               w_mem_we;
    logic [SlotW-1:0]                   w_mem_widx;
    logic signed [kare_pkg::TIME_W-1:0] w_mem_wtime;
    t_state                             n_state;

    always_comb begin
        w_out_free = !r_out_vld || m_axis_tready;
        w_slot_vld = r_valid[r_ev_idx];
        w_is_tick  = (r_cur.cmd == kare_pkg::CMD_TICK);
        w_diff     = {r_rd_time[kare_pkg::TIME_W-1], r_rd_time}
                   - $signed({7'd0, r_cur.delta});
        // only downward overflow is possible: clamp to the most negative time
        if (w_diff[kare_pkg::TIME_W] != w_diff[kare_pkg::TIME_W-1]) begin
            w_tsat = kare_pkg::TIME_MIN;
        end else begin
            w_tsat = w_diff[kare_pkg::TIME_W-1:0];
        end
        w_due   = w_tsat[kare_pkg::TIME_W-1] || (w_tsat == '0);
        w_fire  = r_ev_vld && w_is_tick && w_slot_vld && w_due
               && (r_emit_cnt < kare_pkg::CNT_W'(kare_pkg::MAX_RESULTS));
        // hold the scan while the previous repeat event cannot leave
        w_stall      = w_fire && r_hold_vld && !w_out_free;
        w_advance    = (r_state == S_SCAN) && !w_stall;
        n_time       = w_fire ? w_tsat + $signed({2'd0, i_cfg.period}) : w_tsat;
        w_tick_wr    = r_ev_vld && w_is_tick && w_slot_vld && w_advance;
        w_push_hold  = w_fire && r_hold_vld && !w_stall;
        w_flush_push = (r_state == S_FLUSH) && r_hold_vld && w_out_free;

        w_arm_req    = i_cfg.enable && !r_cur.is_rep && (r_cur.cmd == kare_pkg::CMD_PRESS);
        w_arm_ok     = r_match_vld || r_free_vld;
        w_arm_idx    = r_match_vld ? r_match_idx : r_free_idx;
        w_finish_arm = (r_state == S_FINISH) && w_arm_req && w_arm_ok;
        w_mem_we     = w_tick_wr || w_finish_arm;
        w_mem_widx   = w_finish_arm ? w_arm_idx : r_ev_idx;
        w_mem_wtime  = w_finish_arm ? $signed({2'd0, i_cfg.delay}) : n_time;
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!r_addr_vld && !r_ev_vld) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (!r_hold_vld || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mods      <= '0;
            r_valid     <= '0;
            r_addr_vld  <= 1'b0;
            r_ev_vld    <= 1'b0;
            r_match_vld <= 1'b0;
            r_free_vld  <= 1'b0;
            r_hold_vld  <= 1'b0;
            r_emit_cnt  <= '0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_addr_vld  <= 1'b1;
                r_ev_vld    <= 1'b0;
                r_match_vld <= 1'b0;
                r_free_vld  <= 1'b0;
                r_hold_vld  <= 1'b0;
                r_emit_cnt  <= '0;
            end
            if (w_advance) begin
                r_ev_vld <= r_addr_vld;
                if (r_addr_vld && (r_addr == SlotW'(HELD_SLOTS - 1))) begin
                    r_addr_vld <= 1'b0;
                end
                if (r_ev_vld && w_slot_vld && (r_rd_key == r_cur.key) && !r_match_vld) begin
                    r_match_vld <= 1'b1;
                end
                if (r_ev_vld && !w_slot_vld && !r_free_vld) begin
                    r_free_vld <= 1'b1;
                end
                if (w_fire) begin
                    r_hold_vld <= 1'b1;
                    r_emit_cnt <= r_emit_cnt + 1'b1;
                end
            end
            if (r_state == S_FINISH) begin
                if (!w_is_tick) begin
                    r_mods     <= r_cur.mods;
                    r_hold_vld <= 1'b1;
                end
                if (w_finish_arm) begin
                    r_valid[w_arm_idx] <= 1'b1;
                end
                if ((r_cur.cmd == kare_pkg::CMD_RELEASE) && r_match_vld) begin
                    r_valid[r_match_idx] <= 1'b0;
                end
            end
            if (w_flush_push) begin
                r_hold_vld <= 1'b0;
            end
        end
    end

    // scan pipeline payload and event holding register
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur  <= i_q_item;
            r_addr <= '0;
        end
        if (w_advance) begin
            if (r_addr_vld) begin
                r_rd_key  <= mem_key[r_addr];
                r_rd_time <= mem_time[r_addr];
                r_ev_idx  <= r_addr;
                if (r_addr != SlotW'(HELD_SLOTS - 1)) begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (r_ev_vld && w_slot_vld && (r_rd_key == r_cur.key) && !r_match_vld) begin
                r_match_idx <= r_ev_idx;
            end
            if (r_ev_vld && !w_slot_vld && !r_free_vld) begin
                r_free_idx <= r_ev_idx;
            end
            if (w_fire) begin
                r_hold.kind <= kare_pkg::EV_PRESSED;
                r_hold.key  <= r_rd_key;
                r_hold.mods <= r_mods;
                r_hold.rep  <= 1'b1;
                r_hold.full <= 1'b0;
            end
        end
        if ((r_state == S_FINISH) && !w_is_tick) begin
            r_hold.kind <= (r_cur.cmd == kare_pkg::CMD_RELEASE) ? kare_pkg::EV_RELEASED
                                                                 : kare_pkg::EV_PRESSED;
            r_hold.key  <= r_cur.key;
            r_hold.mods <= r_cur.mods;
            r_hold.rep  <= (r_cur.cmd == kare_pkg::CMD_PRESS) && r_cur.is_rep;
            r_hold.full <= w_arm_req && !w_arm_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_time[w_mem_widx] <= w_mem_wtime;
        end
        if (w_finish_arm) begin
            mem_key[w_mem_widx] <= r_cur.key;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_push_hold || w_flush_push) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_hold || w_flush_push) begin
            r_out      <= r_hold;
            r_out_last <= w_flush_push;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out.full, r_out.rep, r_out.mods, r_out.key};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out_last;

    `KARE_NEVER(a_emit_bound, i_clk, i_rst_n, r_emit_cnt > kare_pkg::CNT_W'(kare_pkg::MAX_RESULTS))
    `KARE_IMPLIES(a_stall_in_scan, i_clk, i_rst_n, w_stall, r_hold_vld && (r_state == S_SCAN))
    `KARE_NEXT(a_key_event, i_clk, i_rst_n, (r_state == S_FINISH) && !w_is_tick, r_hold_vld)
    `KARE_IMPLIES(a_pop_clean, i_clk, i_rst_n, o_q_pop, !r_ev_vld && !r_addr_vld && !r_hold_vld)

endmodule

// File: sv/key_auto_repeat_engine_top.sv
// Top level of the key auto-repeat engine: configuration registers and the
// front/back pair. Depends on kare_pkg, kare_front and kare_back.
//
// Key auto-repeat engine. Requests on the s_axis side are key presses, key
// releases and time ticks (command in tuser); results on the m_axis side are
// pressed/released events (kind in tuser), tlast marking the last event of a
// request. Presses and releases of keys at or above NUM_KEYS, the unused
// command and ticks while repeat is disabled are dropped at the input and give
// no result. Every other request walks the held-key table, one slot per cycle
// through a table memory with one read and one write port. In the back end it
// is popped from the queue, scans the table, updates the table and hands off
// its last event. A tick that fires repeats also waits whenever the output
// register is not drained, and every request waits at its last event until
// the output register frees. A two-entry request queue lets the input side
// keep accepting while the back end works. The table's valid bits clear at
// reset, so no clearing pass runs. Write configuration only while no
// request is in flight.
module key_auto_repeat_engine_top #(
    parameter int NUM_KEYS   = 128,
    parameter int HELD_SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] key_code, [15:8] modifier_bits, [16] press_is_repeat,
    // [28:17] tick_delta_ms, [31:29] zero
    input  logic [kare_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] command
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] event_key, [15:8] event_modifiers, [16] event_repeat,
    // [17] tracking_full, [23:18] zero
    output logic [kare_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] event_kind
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_wr_en,
    input  logic [kare_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kare_pkg::CFG_W-1:0]      i_cfg_wdata
);

    kare_pkg::t_cfg  r_cfg;
    logic            w_q_valid;
    kare_pkg::t_item w_q_item;
    logic            w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable <= kare_pkg::RESET_ENABLE;
            r_cfg.delay  <= kare_pkg::RESET_DELAY;
            r_cfg.period <= kare_pkg::RESET_PERIOD;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                kare_pkg::CFG_IDX_ENABLE: r_cfg.enable <= i_cfg_wdata[0];
                kare_pkg::CFG_IDX_DELAY:  r_cfg.delay  <= i_cfg_wdata;
                kare_pkg::CFG_IDX_PERIOD: begin
                    // clamp short periods to the minimum
                    r_cfg.period <= (i_cfg_wdata < kare_pkg::MIN_PERIOD) ? kare_pkg::MIN_PERIOD
                                                                        : i_cfg_wdata;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    kare_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .i_repeat_enable (r_cfg.enable),
        .o_q_valid       (w_q_valid),
        .o_q_item        (w_q_item),
        .i_q_pop         (w_q_pop)
    );

    kare_back #(
        .HELD_SLOTS (HELD_SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
